/* sv/edf_pkg.sv */
// edf_pkg: shared types and codes for the EDF task scheduler.
// Used by edf_ctrl, edf_dpath and edf_task_scheduler; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package edf_pkg;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_TICK     = 3'd2,
        OP_SCHEDULE = 3'd3,
        OP_YIELD    = 3'd4,
        OP_PREEMPT  = 3'd5,
        OP_COMPLETE = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_TERM    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_IDLE = 2'd1,
        KIND_TASK = 2'd2
    } kind_t;

    localparam logic [31:0] IDLE_DEADLINE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DECIDE,
        S_COUNT,
        S_WAIT
    } state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  task_slot;
        logic [31:0] new_deadline;
        logic [31:0] task_period;
        logic [31:0] elapsed_ticks;
    } req_t;

    typedef struct packed {
        logic [3:0]  running_slot;
        logic [1:0]  running_kind;
        logic        switched;
        logic [31:0] switch_total;
        logic [4:0]  missed_total;
        logic [4:0]  ready_total;
        logic [31:0] time_now;
    } rsp_t;

    typedef struct packed {
        logic load_req;
        logic exec_op;
        logic scan_step;
        logic decide;
        logic count_step;
        logic load_rsp;
    } cmd_t;

    typedef struct packed {
        logic last_idx;
        logic scan_op;
        logic switch_op;
        logic rsp_free;
    } sts_t;

endpackage
`default_nettype wire

/* sv/edf_ctrl.sv */
// edf_ctrl: sequencer for the EDF scheduler.
// Depends on edf_pkg; drives edf_dpath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none
module edf_ctrl
    import edf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = sts.scan_op ? S_SCAN : S_COUNT;
            end
            S_SCAN:
            begin
                if (sts.last_idx)
                begin
                    state_next = sts.switch_op ? S_DECIDE : S_COUNT;
                end
            end
            S_DECIDE:
            begin
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                if (sts.last_idx)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (sts.rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall    = 1'b0;
                cmd.load_req = req_valid;
            end
            S_EXEC:   cmd.exec_op    = 1'b1;
            S_SCAN:   cmd.scan_step  = 1'b1;
            S_DECIDE: cmd.decide     = 1'b1;
            S_COUNT:  cmd.count_step = 1'b1;
            S_WAIT:   cmd.load_rsp   = sts.rsp_free;
            default:  cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* sv/edf_dpath.sv */
// edf_dpath: task table, scan unit, switch logic and response register.
// Depends on edf_pkg; sequenced by edf_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module edf_dpath
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    output sts_t      sts,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

    // task table
    logic                res_reg [MAX_TASKS];
    status_t             st_reg  [MAX_TASKS];
    logic                mis_reg [MAX_TASKS];
    logic [31:0]         dl_reg  [MAX_TASKS];
    logic [31:0]         per_reg [MAX_TASKS];
    logic [31:0]         arr_reg [MAX_TASKS];

    req_t                req_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                best_vld_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [31:0]         best_dl_reg;
    logic [31:0]         best_arr_reg;
    logic [31:0]         cur_dl_reg;
    logic [31:0]         arrival_reg;
    logic [31:0]         tick_reg;
    logic [IDX_W-1:0]    cur_slot_reg;
    kind_t               cur_kind_reg;
    logic [31:0]         sw_cnt_reg;
    logic                switched_reg;
    logic [CNT_W-1:0]    miss_cnt_reg;
    logic [CNT_W-1:0]    rdy_cnt_reg;
    logic                rsp_vld_reg;
    rsp_t                rsp_reg;

    op_t                 op;
    logic                in_table;
    logic [IDX_W-1:0]    slot;
    logic                cand;
    logic                better;
    logic                do_sw;
    kind_t               sw_kind;
    logic                cur_task;

    assign op       = op_t'(req_reg.operation);
    assign in_table = 32'(req_reg.task_slot) < 32'(MAX_TASKS);
    assign slot     = IDX_W'(req_reg.task_slot);
    assign cur_task = (cur_kind_reg == KIND_TASK);

    // candidate for selection at the scan position
    assign cand = res_reg[idx_reg] && (st_reg[idx_reg] == ST_READY) &&
                  !(op == OP_YIELD && cur_task && idx_reg == cur_slot_reg);
    assign better = !best_vld_reg || (dl_reg[idx_reg] < best_dl_reg) ||
                    ((dl_reg[idx_reg] == best_dl_reg) &&
                     (arr_reg[idx_reg] < best_arr_reg));

    // switch decision after the scan
    always_comb
    begin
        do_sw   = 1'b0;
        sw_kind = KIND_TASK;
        case (op)
            OP_SCHEDULE:
            begin
                if (!best_vld_reg)
                begin
                    do_sw   = (cur_kind_reg != KIND_IDLE);
                    sw_kind = KIND_IDLE;
                end
                else
                begin
                    do_sw = !(cur_task && best_idx_reg == cur_slot_reg);
                end
            end
            OP_YIELD:
            begin
                do_sw = (cur_kind_reg != KIND_NONE) && best_vld_reg;
            end
            OP_PREEMPT:
            begin
                if (best_vld_reg && !(cur_task && best_idx_reg == cur_slot_reg))
                begin
                    case (cur_kind_reg)
                        KIND_IDLE: do_sw = best_dl_reg < IDLE_DEADLINE;
                        KIND_TASK: do_sw = best_dl_reg < cur_dl_reg;
                        default:   do_sw = 1'b1;
                    endcase
                end
            end
            default:
            begin
                do_sw = 1'b0;
            end
        endcase
    end

    assign sts.last_idx  = (idx_reg == LAST_IDX);
    assign sts.scan_op   = (op == OP_TICK) || (op == OP_SCHEDULE) ||
                           (op == OP_YIELD) || (op == OP_PREEMPT);
    assign sts.switch_op = (op == OP_SCHEDULE) || (op == OP_YIELD) ||
                           (op == OP_PREEMPT);
    assign sts.rsp_free  = !rsp_vld_reg || !rsp_stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                res_reg[i] <= 1'b0;
            end
            idx_reg      <= '0;
            best_vld_reg <= 1'b0;
            arrival_reg  <= '0;
            tick_reg     <= '0;
            cur_slot_reg <= '0;
            cur_kind_reg <= KIND_NONE;
            sw_cnt_reg   <= '0;
            switched_reg <= 1'b0;
            miss_cnt_reg <= '0;
            rdy_cnt_reg  <= '0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.exec_op)
            begin
                idx_reg      <= '0;
                best_vld_reg <= 1'b0;
                switched_reg <= 1'b0;
                miss_cnt_reg <= '0;
                rdy_cnt_reg  <= '0;
                case (op)
                    OP_ADD:
                    begin
                        if (in_table)
                        begin
                            res_reg[slot] <= 1'b1;
                            arrival_reg   <= arrival_reg + 32'd1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (in_table)
                        begin
                            res_reg[slot] <= 1'b0;
                        end
                    end
                    OP_TICK:
                    begin
                        tick_reg <= tick_reg + req_reg.elapsed_ticks;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.scan_step || cmd.count_step)
            begin
                idx_reg <= sts.last_idx ? '0 : idx_reg + IDX_W'(1);
            end
            if (cmd.scan_step && sts.switch_op && cand && better)
            begin
                best_vld_reg <= 1'b1;
            end
            if (cmd.decide && do_sw)
            begin
                cur_kind_reg <= sw_kind;
                cur_slot_reg <= (sw_kind == KIND_TASK) ? best_idx_reg : '0;
                sw_cnt_reg   <= sw_cnt_reg + 32'd1;
                switched_reg <= 1'b1;
            end
            if (cmd.count_step && res_reg[idx_reg])
            begin
                miss_cnt_reg <= miss_cnt_reg + CNT_W'(mis_reg[idx_reg]);
                rdy_cnt_reg  <= rdy_cnt_reg + CNT_W'(st_reg[idx_reg] == ST_READY ||
                                                     st_reg[idx_reg] == ST_RUNNING);
            end
            if (cmd.load_rsp)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // payload state
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_data;
        end
        if (cmd.exec_op)
        begin
            case (op)
                OP_ADD:
                begin
                    if (in_table)
                    begin
                        dl_reg[slot]  <= req_reg.new_deadline;
                        per_reg[slot] <= req_reg.task_period;
                        st_reg[slot]  <= ST_READY;
                        mis_reg[slot] <= 1'b0;
                        arr_reg[slot] <= arrival_reg;
                    end
                end
                OP_REMOVE:
                begin
                    if (in_table)
                    begin
                        st_reg[slot] <= ST_TERM;
                    end
                end
                OP_COMPLETE:
                begin
                    if (in_table && res_reg[slot])
                    begin
                        st_reg[slot] <= ST_TERM;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.scan_step)
        begin
            if (op == OP_TICK)
            begin
                // flag misses, then rearm terminated periodic tasks
                if (res_reg[idx_reg])
                begin
                    if ((st_reg[idx_reg] == ST_READY || st_reg[idx_reg] == ST_RUNNING) &&
                        tick_reg > dl_reg[idx_reg])
                    begin
                        mis_reg[idx_reg] <= 1'b1;
                    end
                    if (per_reg[idx_reg] != 32'd0 && st_reg[idx_reg] == ST_TERM)
                    begin
                        dl_reg[idx_reg]  <= dl_reg[idx_reg] + per_reg[idx_reg];
                        mis_reg[idx_reg] <= 1'b0;
                        st_reg[idx_reg]  <= ST_READY;
                    end
                end
            end
            else
            begin
                if (cand && better)
                begin
                    best_idx_reg <= idx_reg;
                    best_dl_reg  <= dl_reg[idx_reg];
                    best_arr_reg <= arr_reg[idx_reg];
                end
                if (idx_reg == cur_slot_reg)
                begin
                    cur_dl_reg <= dl_reg[idx_reg];
                end
            end
        end
        if (cmd.decide && do_sw)
        begin
            // demote the outgoing task, then mark the new one running
            if (cur_task && res_reg[cur_slot_reg] && st_reg[cur_slot_reg] == ST_RUNNING)
            begin
                st_reg[cur_slot_reg] <= ST_READY;
            end
            if (sw_kind == KIND_TASK)
            begin
                st_reg[best_idx_reg] <= ST_RUNNING;
            end
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.running_slot <= cur_task ? 4'(cur_slot_reg) : 4'd0;
            rsp_reg.running_kind <= cur_kind_reg;
            rsp_reg.switched     <= switched_reg;
            rsp_reg.switch_total <= sw_cnt_reg;
            rsp_reg.missed_total <= 5'(miss_cnt_reg);
            rsp_reg.ready_total  <= 5'(rdy_cnt_reg);
            rsp_reg.time_now     <= tick_reg;
        end
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp_data  = rsp_reg;

    a_best_resident: assert property (@(posedge clk) disable iff (!rst_n)
        best_vld_reg |-> res_reg[best_idx_reg])
        else $error("selected slot is not resident");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rdy_cnt_reg) <= 32'(MAX_TASKS) && 32'(miss_cnt_reg) <= 32'(MAX_TASKS))
        else $error("slot count exceeds table size");

    a_switch_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (sw_cnt_reg != $past(sw_cnt_reg)) |-> switched_reg)
        else $error("switch counted without switch flag");

endmodule
`default_nettype wire

/* sv/edf_task_scheduler.sv */
// EDF task scheduler: one request in, one response out, one request at a time.
// Tick runs a table scan, and schedule/yield/preempt run a scan and a switch step, before
// the count pass; other ops run the count pass only.
// A new request is taken only after the last response is loaded; the next request is taken
// while a response waits.
// Reset: rst_n async low clears residency, time, counters and running task (none).
`timescale 1ns / 1ps
`default_nettype none
module edf_task_scheduler
    import edf_pkg::*;
#(
    parameter int MAX_TASKS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    // Controller steps the datapath through: take request, execute the
    // slot-addressed part, scan the table (tick update or EDF selection),
    // apply the switch, count missed/ready slots, then hand off the response.
    cmd_t cmd;
    sts_t sts;

    edf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath holds the task table, scan registers and response register.
    edf_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// tb_top: self-checking bench for edf_task_scheduler (EDF scheduler over 16 slots).
// Depends on edf_pkg and the edf_task_scheduler RTL; a scoreboard class predicts responses.
`timescale 1ns / 1ps

module tb_top;
    import edf_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int STALL_LIMIT = 20000;

    // Scoreboard: shadow copy of the task table and the expected responses
    class edf_scoreboard;
        bit          resident [NUM_SLOTS];
        logic [31:0] deadline [NUM_SLOTS];
        logic [31:0] period   [NUM_SLOTS];
        status_t     status   [NUM_SLOTS];
        bit          missed   [NUM_SLOTS];
        logic [31:0] arrival  [NUM_SLOTS];
        logic [31:0] arrival_next;
        logic [31:0] ticks;
        logic [3:0]  cur_slot;
        kind_t       cur_kind;
        logic [31:0] switches;
        rsp_t        pending_rsp [$];
        int          errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                resident[i] = 0; deadline[i] = 0; period[i] = 0;
                status[i] = ST_READY; missed[i] = 0; arrival[i] = 0;
            end
            arrival_next = 0; ticks = 0; cur_slot = 0; cur_kind = KIND_NONE;
            switches = 0; errors = 0;
        endfunction

        function int earliest_ready(int skip);
            int best;
            best = -1;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (!resident[i] || status[i] != ST_READY || i == skip)
                    continue;
                if (best < 0 || deadline[i] < deadline[best] ||
                    (deadline[i] == deadline[best] && arrival[i] < arrival[best]))
                    best = i;
            end
            return best;
        endfunction

        function void switch_to(kind_t kind, int slot);
            if (cur_kind == KIND_TASK && resident[cur_slot] && status[cur_slot] == ST_RUNNING)
                status[cur_slot] = ST_READY;
            cur_kind = kind;
            cur_slot = (kind == KIND_TASK) ? slot[3:0] : 4'd0;
            if (kind == KIND_TASK)
                status[slot] = ST_RUNNING;
            switches++;
        endfunction

        // Note an accepted request: advance the shadow state, queue the response
        function void note_request(req_t rq);
            int   cur, best, s;
            bit   sw, go;
            rsp_t r;
            cur = (cur_kind == KIND_TASK) ? int'(cur_slot) : -1;
            s = rq.task_slot;
            sw = 0;
            case (rq.operation)
                OP_ADD:
                begin
                    resident[s] = 1; deadline[s] = rq.new_deadline;
                    period[s] = rq.task_period; status[s] = ST_READY;
                    missed[s] = 0; arrival[s] = arrival_next++;
                end
                OP_REMOVE:
                begin
                    resident[s] = 0; status[s] = ST_TERM;
                end
                OP_TICK:
                begin
                    ticks += rq.elapsed_ticks;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!resident[i])
                            continue;
                        if ((status[i] == ST_READY || status[i] == ST_RUNNING) &&
                            ticks > deadline[i])
                            missed[i] = 1;
                        if (period[i] != 0 && status[i] == ST_TERM)
                        begin
                            deadline[i] += period[i]; missed[i] = 0; status[i] = ST_READY;
                        end
                    end
                end
                OP_SCHEDULE:
                begin
                    best = earliest_ready(-1);
                    if (best < 0)
                    begin
                        if (cur_kind != KIND_IDLE)
                        begin
                            switch_to(KIND_IDLE, 0); sw = 1;
                        end
                    end
                    else if (best != cur)
                    begin
                        switch_to(KIND_TASK, best); sw = 1;
                    end
                end
                OP_YIELD:
                begin
                    if (cur_kind != KIND_NONE)
                    begin
                        best = earliest_ready(cur);
                        if (best >= 0)
                        begin
                            switch_to(KIND_TASK, best); sw = 1;
                        end
                    end
                end
                OP_PREEMPT:
                begin
                    best = earliest_ready(-1);
                    if (best >= 0 && best != cur)
                    begin
                        go = 1;
                        if (cur_kind == KIND_IDLE)
                            go = deadline[best] < IDLE_DEADLINE;
                        else if (cur_kind == KIND_TASK)
                            go = deadline[best] < deadline[cur_slot];
                        if (go)
                        begin
                            switch_to(KIND_TASK, best); sw = 1;
                        end
                    end
                end
                OP_COMPLETE:
                begin
                    if (resident[s])
                        status[s] = ST_TERM;
                end
                default: ;
            endcase
            r = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (!resident[i])
                    continue;
                if (missed[i])
                    r.missed_total++;
                if (status[i] == ST_READY || status[i] == ST_RUNNING)
                    r.ready_total++;
            end
            r.running_slot = (cur_kind == KIND_TASK) ? cur_slot : 4'd0;
            r.running_kind = cur_kind;
            r.switched     = sw;
            r.switch_total = switches;
            r.time_now     = ticks;
            pending_rsp.push_back(r);
        endfunction

        // Compare an accepted response with the oldest expected one
        function void check_response(rsp_t got);
            rsp_t exp;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response %h", $time, got);
                errors++;
                return;
            end
            exp = pending_rsp.pop_front();
            if (got.running_slot !== exp.running_slot)
            begin
                $display("%0t: running_slot exp %0d got %0d", $time,
                         exp.running_slot, got.running_slot); errors++;
            end
            if (got.running_kind !== exp.running_kind)
            begin
                $display("%0t: running_kind exp %0d got %0d", $time,
                         exp.running_kind, got.running_kind); errors++;
            end
            if (got.switched !== exp.switched)
            begin
                $display("%0t: switched exp %0d got %0d", $time,
                         exp.switched, got.switched); errors++;
            end
            if (got.switch_total !== exp.switch_total)
            begin
                $display("%0t: switch_total exp %0d got %0d", $time,
                         exp.switch_total, got.switch_total); errors++;
            end
            if (got.missed_total !== exp.missed_total)
            begin
                $display("%0t: missed_total exp %0d got %0d", $time,
                         exp.missed_total, got.missed_total); errors++;
            end
            if (got.ready_total !== exp.ready_total)
            begin
                $display("%0t: ready_total exp %0d got %0d", $time,
                         exp.ready_total, got.ready_total); errors++;
            end
            if (got.time_now !== exp.time_now)
            begin
                $display("%0t: time_now exp %h got %h", $time,
                         exp.time_now, got.time_now); errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp_data;

    edf_scoreboard sched_sb;
    bit            stim_done;
    bit            hold_rsp;
    int            idle_cycles;
    int            bench_fail;
    bit            ever_written [NUM_SLOTS];

    edf_task_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request and hold it until accepted; note it at acceptance.
    // Drop valid during a gap; keep it high for a back-to-back request.
    task automatic send_request(req_t rq);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= rq;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        sched_sb.note_request(rq);
        if (rq.operation == OP_ADD)
            ever_written[rq.task_slot] = 1;
    endtask

    function automatic req_t make_req(op_t op, int slot, logic [31:0] dl,
                                      logic [31:0] per, logic [31:0] el);
        req_t rq;
        rq.operation = op; rq.task_slot = slot[3:0];
        rq.new_deadline = dl; rq.task_period = per; rq.elapsed_ticks = el;
        return rq;
    endfunction

    // Random request: mostly adds, ticks and switches with small time values
    function automatic req_t rand_req();
        req_t rq;
        int   roll;
        rq.task_slot     = 4'($urandom_range(0, 15));
        rq.new_deadline  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 400);
        rq.task_period   = ($urandom_range(0, 9) == 0) ? $urandom() :
                           ($urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(1, 100));
        rq.elapsed_ticks = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 30);
        roll = $urandom_range(0, 99);
        if (roll < 25)      rq.operation = OP_ADD;
        else if (roll < 33) rq.operation = OP_REMOVE;
        else if (roll < 48) rq.operation = OP_TICK;
        else if (roll < 63) rq.operation = OP_SCHEDULE;
        else if (roll < 73) rq.operation = OP_YIELD;
        else if (roll < 83) rq.operation = OP_PREEMPT;
        else if (roll < 97) rq.operation = OP_COMPLETE;
        else                rq.operation = op_t'(3'd7);
        // Never touch a slot whose table entry has not been written yet
        if (rq.operation inside {OP_REMOVE, OP_COMPLETE} && !ever_written[rq.task_slot])
            rq.operation = OP_ADD;
        return rq;
    endfunction

    // Stimulus: directed corner cases, then random traffic
    initial
    begin
        sched_sb   = new();
        req_valid  = 1'b0;
        req_data   = '0;
        rst_n      = 1'b0;
        stim_done  = 0;
        bench_fail = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            ever_written[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Switches with an empty table, then idle-deadline preempt edge
        send_request(make_req(OP_YIELD, 0, 0, 0, 0));
        send_request(make_req(OP_PREEMPT, 0, 0, 0, 0));
        send_request(make_req(OP_SCHEDULE, 0, 0, 0, 0));
        send_request(make_req(OP_SCHEDULE, 0, 0, 0, 0));
        send_request(make_req(OP_ADD, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        send_request(make_req(OP_PREEMPT, 0, 0, 0, 0));
        // Tie on deadline goes to the earlier arrival
        send_request(make_req(OP_ADD, 3, 50, 0, 0));
        send_request(make_req(OP_ADD, 1, 50, 10, 0));
        send_request(make_req(OP_PREEMPT, 0, 0, 0, 0));
        send_request(make_req(OP_YIELD, 0, 0, 0, 0));
        // Re-add the running slot, remove it while running, complete and rearm
        send_request(make_req(OP_ADD, 1, 20, 10, 0));
        send_request(make_req(OP_SCHEDULE, 0, 0, 0, 0));
        send_request(make_req(OP_REMOVE, 1, 0, 0, 0));
        send_request(make_req(OP_YIELD, 0, 0, 0, 0));
        send_request(make_req(OP_COMPLETE, 1, 0, 0, 0));
        send_request(make_req(OP_ADD, 0, 0, 5, 0));
        send_request(make_req(OP_COMPLETE, 0, 0, 0, 0));
        send_request(make_req(OP_TICK, 0, 0, 0, 60));
        send_request(make_req(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_req(OP_SCHEDULE, 0, 0, 0, 0));
        send_request(make_req(OP_PREEMPT, 0, 0, 0, 0));
        send_request(make_req(op_t'(3'd7), 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF));

        for (int n = 0; n < 800; n++)
            send_request(rand_req());
        stim_done = 1;
        req_valid <= 1'b0;
    end

    // Response side: random stall, with one long hold-off to fill the block
    initial
    begin
        int gap;
        int accepted;
        rsp_stall = 1'b1;
        hold_rsp  = 0;
        accepted  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                sched_sb.check_response(rsp_data);
                accepted++;
            end
            if (accepted == 300 && !hold_rsp)
            begin
                hold_rsp = 1;
                rsp_stall <= 1'b1;
                repeat (400) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            else
            begin
                gap = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
                rsp_stall <= (gap > 0) || ($urandom_range(0, 9) == 0);
            end
        end
    end

    // Watchdog and end of run
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            if (stim_done && sched_sb.pending_rsp.size() == 0)
                break;
        end
        // Catch any stray response before ending the run
        repeat (4 * NUM_SLOTS + 20) @(posedge clk);
        if (sched_sb.errors == 0 && sched_sb.pending_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
